[rtl/core/cartridge_bank_mapper_irq_macros.svh]
// Assertion macros shared by the cartridge bank mapper RTL.
// Both macros expect a signal named clk in the scope that uses them; CBM_ASSERT also expects rst_n.
`ifndef CARTRIDGE_BANK_MAPPER_IRQ_MACROS_SVH
`define CARTRIDGE_BANK_MAPPER_IRQ_MACROS_SVH

// The property is checked on every clock edge outside reset.
`define CBM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// The property is also checked while reset is held.
`define CBM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/cbm_pkg.sv]
// Types and constants for the cartridge bank mapper.
// Used by cbm_core and cartridge_bank_mapper_irq; depends on nothing else.
`timescale 1ns / 1ps

package cbm_pkg;

  localparam int unsigned WINDOW_COUNT = 11;
  localparam int unsigned PRG_WINDOWS  = 3;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_PRG   = 2'd2;
  localparam logic [1:0] OP_PAT   = 2'd3;

  localparam logic [15:0] DEC_MASK = 16'hF003;

  localparam logic [3:0] DEC_PRG01 = 4'h8;
  localparam logic [3:0] DEC_PRG2  = 4'h9;
  localparam logic [3:0] DEC_PAT01 = 4'hA;
  localparam logic [3:0] DEC_PAT23 = 4'hB;
  localparam logic [3:0] DEC_PAT45 = 4'hC;
  localparam logic [3:0] DEC_PAT67 = 4'hD;
  localparam logic [3:0] DEC_LATCH = 4'hE;
  localparam logic [3:0] DEC_CTRL  = 4'hF;

  localparam logic [1:0] CTRL_LOAD   = 2'd0;
  localparam logic [1:0] CTRL_ACK    = 2'd1;
  localparam logic [1:0] CTRL_MIRROR = 2'd2;

  localparam logic [8:0] PRG_COUNT_RESET = 9'd32;
  localparam logic [7:0] PRG2_RESET      = 8'(PRG_COUNT_RESET - 9'd2);

  typedef logic [7:0] bank_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic [9:0]  tick_cycles;
  } in_item_t;

  typedef struct packed {
    logic [7:0] bank_number;
    logic       irq_line;
    logic [1:0] mirroring_mode;
  } out_item_t;

endpackage

[rtl/core/cbm_core.sv]
// Mapper state (bank windows, reload latch, down-counter, interrupt, mirroring)
// and the single-pass logic that applies one transaction. Depends on cbm_pkg and the assertion macros.
`timescale 1ns / 1ps
`include "cartridge_bank_mapper_irq_macros.svh"

module cbm_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  cbm_pkg::in_item_t item,
  input  logic [8:0]        prg_bank_count,
  output cbm_pkg::out_item_t result
);

  cbm_pkg::bank_t win_r   [cbm_pkg::WINDOW_COUNT];
  cbm_pkg::bank_t win_nxt [cbm_pkg::WINDOW_COUNT];
  logic [15:0] latch_r, latch_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic        en_r, en_nxt;
  logic        irq_r, irq_nxt;
  logic [1:0]  mir_r, mir_nxt;

  logic [15:0] dec;
  logic [3:0]  dec_hi;
  logic [1:0]  dec_lo;
  logic        bus_wr;
  logic        win_wr_en;
  logic [3:0]  win_idx;
  logic [3:0]  rd_idx;
  logic [8:0]  fixed_bank;
  logic [15:0] cycles_ext;
  cbm_pkg::bank_t bank;

  assign dec        = item.address & cbm_pkg::DEC_MASK;
  assign dec_hi     = dec[15:12];
  assign dec_lo     = dec[1:0];
  assign bus_wr     = fire && (item.operation == cbm_pkg::OP_WRITE) && item.address[15];
  assign cycles_ext = {6'd0, item.tick_cycles};
  assign fixed_bank = prg_bank_count - 9'd1;

  // Window decode: bit 1 of the address picks the window of a pair, bit 0 the nibble.
  always_comb begin
    win_wr_en = 1'b0;
    win_idx   = '0;
    unique case (dec_hi)
      cbm_pkg::DEC_PRG01: begin
        win_wr_en = bus_wr;
        win_idx   = {3'd0, dec_lo[1]};
      end
      cbm_pkg::DEC_PRG2: begin
        win_wr_en = bus_wr && !dec_lo[1];
        win_idx   = 4'd2;
      end
      cbm_pkg::DEC_PAT01, cbm_pkg::DEC_PAT23, cbm_pkg::DEC_PAT45, cbm_pkg::DEC_PAT67: begin
        win_wr_en = bus_wr;
        win_idx   = 4'(cbm_pkg::PRG_WINDOWS) + {1'b0, ~dec_hi[1], dec_hi[0], dec_lo[1]};
      end
      default: begin
        win_wr_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < cbm_pkg::WINDOW_COUNT; i++) begin
      win_nxt[i] = win_r[i];
      if (win_wr_en && (win_idx == 4'(i))) begin
        if (dec_lo[0]) begin
          win_nxt[i] = {item.write_data[3:0], win_r[i][3:0]};
        end else begin
          win_nxt[i] = {win_r[i][7:4], item.write_data[3:0]};
        end
      end
    end
  end

  always_comb begin
    latch_nxt = latch_r;
    cnt_nxt   = cnt_r;
    en_nxt    = en_r;
    irq_nxt   = irq_r;
    mir_nxt   = mir_r;
    if (fire) begin
      unique case (item.operation)
        cbm_pkg::OP_WRITE: begin
          if (item.address[15] && (dec_hi == cbm_pkg::DEC_LATCH)) begin
            unique case (dec_lo)
              2'd0:    latch_nxt[3:0]   = item.write_data[3:0];
              2'd1:    latch_nxt[7:4]   = item.write_data[3:0];
              2'd2:    latch_nxt[11:8]  = item.write_data[3:0];
              default: latch_nxt[15:12] = item.write_data[3:0];
            endcase
          end else if (item.address[15] && (dec_hi == cbm_pkg::DEC_CTRL)) begin
            unique case (dec_lo)
              cbm_pkg::CTRL_LOAD: cnt_nxt = latch_r;
              cbm_pkg::CTRL_ACK: begin
                irq_nxt = 1'b0;
                en_nxt  = item.write_data[0];
              end
              cbm_pkg::CTRL_MIRROR: mir_nxt = item.write_data[1:0];
              default: begin
                cnt_nxt = cnt_r;
              end
            endcase
          end
        end
        cbm_pkg::OP_TICK: begin
          // The count clamps at zero when the tick covers what is left.
          if (en_r) begin
            if (cnt_r <= cycles_ext) begin
              cnt_nxt = '0;
              en_nxt  = 1'b0;
              irq_nxt = 1'b1;
            end else begin
              cnt_nxt = cnt_r - cycles_ext;
            end
          end
        end
        default: begin
          cnt_nxt = cnt_r;
        end
      endcase
    end
  end

  // One read port serves both kinds of lookup.
  always_comb begin
    if (item.operation == cbm_pkg::OP_PAT) begin
      rd_idx = 4'(cbm_pkg::PRG_WINDOWS) + {1'b0, item.address[12:10]};
    end else begin
      rd_idx = {2'd0, item.address[14:13]};
    end
  end

  always_comb begin
    bank = '0;
    if (item.operation == cbm_pkg::OP_PRG) begin
      if (item.address[15]) begin
        if (item.address[14:13] == 2'b11) begin
          bank = fixed_bank[7:0];
        end else begin
          bank = win_r[rd_idx];
        end
      end
    end else if (item.operation == cbm_pkg::OP_PAT) begin
      bank = win_r[rd_idx];
    end
  end

  assign result.bank_number    = bank;
  assign result.irq_line       = irq_nxt;
  assign result.mirroring_mode = mir_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r[0] <= '0;
      win_r[1] <= 8'd1;
      win_r[2] <= cbm_pkg::PRG2_RESET;
      for (int i = cbm_pkg::PRG_WINDOWS; i < cbm_pkg::WINDOW_COUNT; i++) begin
        win_r[i] <= '0;
      end
      latch_r  <= '0;
      cnt_r    <= '0;
      en_r     <= 1'b0;
      irq_r    <= 1'b0;
      mir_r    <= '0;
    end else begin
      for (int i = 0; i < cbm_pkg::WINDOW_COUNT; i++) begin
        win_r[i] <= win_nxt[i];
      end
      latch_r <= latch_nxt;
      cnt_r   <= cnt_nxt;
      en_r    <= en_nxt;
      irq_r   <= irq_nxt;
      mir_r   <= mir_nxt;
    end
  end

  `CBM_ASSERT(a_irq_rise_on_expiry, $rose(irq_r) |-> (!en_r && (cnt_r == 16'd0)), "interrupt raised without counter expiry")
  `CBM_ASSERT_ALWAYS(a_enable_irq_exclusive, !rst_n || !(en_r && irq_r), "counter enabled while interrupt pending")
  `CBM_ASSERT(a_disabled_tick_holds, (fire && (item.operation == cbm_pkg::OP_TICK) && !en_r) |=> $stable(cnt_r), "disabled counter changed on tick")

endmodule

[rtl/core/cartridge_bank_mapper_irq.sv]
// Top level of the cartridge bank mapper: input register, mapper core, result register
// and the bank count register. Depends on cbm_pkg and cbm_core.
`timescale 1ns / 1ps

// Channel   Direction  Handshake               Payload
// in_       input      in_valid / in_ready     cbm_pkg::in_item_t
// out_      output     out_valid / out_ready   cbm_pkg::out_item_t
// cfg_      input      cfg_wr_en               9-bit program bank count
//
// One transaction a cycle while the result side is ready; a transaction passes from the input register
// to the result register, and a stall on the result side can hold it in either register.
// The mapper state is updated as a transaction moves from the input register to the
// result register, so successive transactions see each other's effects in order.
// A stalled result register still leaves the input register free for one more transaction.
// Reset is synchronous; the bank count returns to 32 and the third program window to 30.

module cartridge_bank_mapper_irq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  cbm_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output cbm_pkg::out_item_t  out_item,
  input  logic                cfg_wr_en,
  input  logic [8:0]          cfg_wr_data
);

  logic               in_vld_r, in_vld_nxt;
  cbm_pkg::in_item_t  in_item_r;
  logic               out_vld_r, out_vld_nxt;
  cbm_pkg::out_item_t out_item_r;
  logic [8:0]         prg_count_r;
  logic               adv;
  logic               fire;
  logic               in_take;
  cbm_pkg::out_item_t result;

  assign adv      = !out_vld_r || out_ready;
  assign fire     = in_vld_r && adv;
  assign in_ready = !in_vld_r || adv;
  assign in_take  = in_valid && in_ready;

  assign in_vld_nxt  = in_take || (in_vld_r && !adv);
  assign out_vld_nxt = fire || (out_vld_r && !out_ready);

  cbm_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .fire           (fire),
    .item           (in_item_r),
    .prg_bank_count (prg_count_r),
    .result         (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r    <= 1'b0;
      out_vld_r   <= 1'b0;
      prg_count_r <= cbm_pkg::PRG_COUNT_RESET;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (cfg_wr_en) begin
        prg_count_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r <= in_item;
    end
    if (fire) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_vld_r;
  assign out_item  = out_item_r;

endmodule

[dv/cartridge_bank_mapper_irq_check.sv]
// Checker for the cartridge bank mapper: watches the input, result and register ports,
// predicts every result and compares it field by field. Depends on cbm_pkg.
`timescale 1ns / 1ps

module cartridge_bank_mapper_irq_check (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  cbm_pkg::in_item_t  in_item,
  input  logic               out_valid,
  input  logic               out_ready,
  input  cbm_pkg::out_item_t out_item,
  input  logic               cfg_wr_en,
  input  logic [8:0]         cfg_wr_data,
  output int                 mismatches,
  output int                 results_checked,
  output int                 irq_results
);

  localparam int         PAT_BASE   = cbm_pkg::PRG_WINDOWS;
  localparam logic [1:0] FIXED_SLOT = 2'(cbm_pkg::PRG_WINDOWS);

  // Mirror of the mapper state.
  logic [8:0]      bank_count;
  cbm_pkg::bank_t  win_bank [cbm_pkg::WINDOW_COUNT];
  logic [15:0]     reload_latch;
  logic [15:0]     irq_counter;
  logic            counter_run;
  logic            irq_pending;
  logic [1:0]      mirror_sel;

  cbm_pkg::out_item_t bank_results_due[$];
  int                 fail_n;
  int                 result_n;
  int                 irq_n;

  function automatic void put_nibble(input int idx, input logic upper, input logic [3:0] nib);
    if (upper) begin
      win_bank[idx][7:4] = nib;
    end else begin
      win_bank[idx][3:0] = nib;
    end
  endfunction

  // Applies one bus access or tick to the mirrored state and returns the result it gives.
  function automatic cbm_pkg::out_item_t predict_access(input cbm_pkg::in_item_t acc);
    logic [15:0]        dec;
    logic [3:0]         dec_hi;
    logic [1:0]         dec_lo;
    cbm_pkg::out_item_t res;
    dec    = acc.address & cbm_pkg::DEC_MASK;
    dec_hi = dec[15:12];
    dec_lo = dec[1:0];
    res    = '0;
    case (acc.operation)
      cbm_pkg::OP_WRITE: if (acc.address[15]) begin
        case (dec_hi)
          cbm_pkg::DEC_PRG01: put_nibble(int'(dec_lo[1]), dec_lo[0], acc.write_data[3:0]);
          cbm_pkg::DEC_PRG2: if (!dec_lo[1]) begin
            put_nibble(cbm_pkg::PRG_WINDOWS - 1, dec_lo[0], acc.write_data[3:0]);
          end
          cbm_pkg::DEC_PAT01, cbm_pkg::DEC_PAT23, cbm_pkg::DEC_PAT45,
          cbm_pkg::DEC_PAT67: begin
            put_nibble(PAT_BASE + 2 * int'(dec_hi - cbm_pkg::DEC_PAT01) + int'(dec_lo[1]),
                       dec_lo[0], acc.write_data[3:0]);
          end
          cbm_pkg::DEC_LATCH: reload_latch[4 * dec_lo +: 4] = acc.write_data[3:0];
          cbm_pkg::DEC_CTRL: begin
            case (dec_lo)
              cbm_pkg::CTRL_LOAD: irq_counter = reload_latch;
              cbm_pkg::CTRL_ACK: begin
                irq_pending = 1'b0;
                counter_run = acc.write_data[0];
              end
              cbm_pkg::CTRL_MIRROR: mirror_sel = acc.write_data[1:0];
              default: ;
            endcase
          end
          default: ;
        endcase
      end
      cbm_pkg::OP_TICK: if (counter_run) begin
        // A count at or below the elapsed cycles expires, zero included.
        if (irq_counter <= {6'd0, acc.tick_cycles}) begin
          irq_counter = '0;
          counter_run = 1'b0;
          irq_pending = 1'b1;
        end else begin
          irq_counter = irq_counter - {6'd0, acc.tick_cycles};
        end
      end
      cbm_pkg::OP_PRG: if (acc.address[15]) begin
        if (acc.address[14:13] == FIXED_SLOT) begin
          res.bank_number = cbm_pkg::bank_t'(bank_count - 9'd1);
        end else begin
          res.bank_number = win_bank[acc.address[14:13]];
        end
      end
      default: res.bank_number = win_bank[PAT_BASE + int'(acc.address[12:10])];
    endcase
    res.irq_line       = irq_pending;
    res.mirroring_mode = mirror_sel;
    return res;
  endfunction

  always @(posedge clk) begin
    cbm_pkg::out_item_t want;
    if (!rst_n) begin
      bank_count = cbm_pkg::PRG_COUNT_RESET;
      for (int i = 0; i < cbm_pkg::WINDOW_COUNT; i++) begin
        win_bank[i] = '0;
      end
      win_bank[1] = 8'd1;
      win_bank[cbm_pkg::PRG_WINDOWS - 1] = cbm_pkg::bank_t'(cbm_pkg::PRG_COUNT_RESET - 9'd2);
      reload_latch = '0;
      irq_counter  = '0;
      counter_run  = 1'b0;
      irq_pending  = 1'b0;
      mirror_sel   = '0;
      bank_results_due.delete();
      fail_n   = 0;
      result_n = 0;
      irq_n    = 0;
    end else begin
      // The result channel is checked first: a result can never belong to the
      // transaction accepted at the same edge.
      if (out_valid && out_ready) begin
        if (bank_results_due.size() == 0) begin
          if (fail_n < 10) begin
            $display("%0t: result with nothing outstanding: bank %0d irq %0b mirror %0d",
                     $realtime, out_item.bank_number, out_item.irq_line,
                     out_item.mirroring_mode);
          end
          fail_n++;
        end else begin
          want = bank_results_due.pop_front();
          if (out_item.bank_number !== want.bank_number || out_item.irq_line !== want.irq_line ||
              out_item.mirroring_mode !== want.mirroring_mode) begin
            if (fail_n < 10) begin
              $display("%0t: result %0d expected bank %0d irq %0b mirror %0d, got %0d %0b %0d",
                       $realtime, result_n, want.bank_number, want.irq_line,
                       want.mirroring_mode, out_item.bank_number, out_item.irq_line,
                       out_item.mirroring_mode);
            end
            fail_n++;
          end
        end
        result_n++;
        if (out_item.irq_line) begin
          irq_n++;
        end
      end
      if (cfg_wr_en) begin
        bank_count = cfg_wr_data;
      end
      if (in_valid && in_ready) begin
        bank_results_due.push_back(predict_access(in_item));
      end
    end
    mismatches      <= fail_n;
    results_checked <= result_n;
    irq_results     <= irq_n;
  end

endmodule

[dv/cartridge_bank_mapper_irq_test.sv]
// Top of the cartridge bank mapper testbench: clock, reset, bus and tick stimulus,
// result back-pressure and the verdict. Depends on cbm_pkg, the mapper and its checker.
`timescale 1ns / 1ps

module cartridge_bank_mapper_irq_test;

  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 90;
  localparam int QUIET_LIMIT = 2000;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  cbm_pkg::in_item_t  in_item;
  logic               out_valid;
  logic               out_ready;
  cbm_pkg::out_item_t out_item;
  logic               cfg_wr_en;
  logic [8:0]         cfg_wr_data;

  int         mismatches;
  int         results_checked;
  int         irq_results;
  int         items_sent = 0;
  bit         idle_on    = 1'b1;
  int         idle_odds  = 3;

  always #5 clk = ~clk;

  cartridge_bank_mapper_irq uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_item    (out_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  cartridge_bank_mapper_irq_check mapper_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_item         (in_item),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_item        (out_item),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .mismatches      (mismatches),
    .results_checked (results_checked),
    .irq_results     (irq_results)
  );

  // Offers one transaction, possibly after an idle burst, and returns once it is taken.
  task automatic access(input logic [1:0] op, input logic [15:0] addr,
                        input logic [7:0] data, input logic [9:0] cycles);
    cbm_pkg::in_item_t it;
    it.operation   = op;
    it.address     = addr;
    it.write_data  = (op == cbm_pkg::OP_WRITE) ? data : 8'($urandom);
    it.tick_cycles = (op == cbm_pkg::OP_TICK) ? cycles : 10'($urandom);
    if (idle_on && $urandom_range(0, idle_odds) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // Loads the reload latch nibble by nibble, copies it into the counter and acknowledges.
  task automatic arm_timer(input logic [15:0] count, input logic enable);
    for (int n = 0; n < 4; n++) begin
      access(cbm_pkg::OP_WRITE, {cbm_pkg::DEC_LATCH, 10'($urandom), 2'(n)},
             {4'($urandom), count[4 * n +: 4]}, '0);
    end
    access(cbm_pkg::OP_WRITE, {cbm_pkg::DEC_CTRL, 10'($urandom), cbm_pkg::CTRL_LOAD},
           8'($urandom), '0);
    access(cbm_pkg::OP_WRITE, {cbm_pkg::DEC_CTRL, 10'($urandom), cbm_pkg::CTRL_ACK},
           {7'($urandom), enable}, '0);
  endtask

  // Result side back-pressure.
  initial begin
    out_ready = 1'b0;
    @(posedge clk);
    forever begin
      if (idle_on && $urandom_range(0, idle_odds) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  // Ends the run when neither channel nor the register port moves for too long.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("timeout after %0d quiet cycles", QUIET_LIMIT);
    $display("status: fail");
    $finish;
  end

  initial begin
    int          target;
    int          pick;
    logic [8:0]  setting;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_item     = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset banks first, then writes to program and pattern decodes including ignored ones, then the counter.
    access(cbm_pkg::OP_PRG, 16'h0000, '0, '0);
    access(cbm_pkg::OP_PRG, 16'hC000, '0, '0);
    access(cbm_pkg::OP_PRG, 16'hFFFF, '0, '0);
    access(cbm_pkg::OP_PAT, 16'h1FFF, '0, '0);
    access(cbm_pkg::OP_WRITE, 16'h7FFF, 8'hFF, '0);
    access(cbm_pkg::OP_WRITE, {cbm_pkg::DEC_PRG01, 10'h3FF, 2'd0}, 8'h5A, '0);
    access(cbm_pkg::OP_WRITE, {cbm_pkg::DEC_PRG01, 10'h000, 2'd1}, 8'hFF, '0);
    access(cbm_pkg::OP_WRITE, {cbm_pkg::DEC_PRG01, 10'h155, 2'd3}, 8'h0C, '0);
    access(cbm_pkg::OP_WRITE, {cbm_pkg::DEC_PRG2, 10'h2AA, 2'd1}, 8'hF7, '0);
    access(cbm_pkg::OP_WRITE, {cbm_pkg::DEC_PRG2, 10'h000, 2'd3}, 8'hFF, '0);
    access(cbm_pkg::OP_WRITE, {cbm_pkg::DEC_PAT01, 10'h000, 2'd2}, 8'h0F, '0);
    access(cbm_pkg::OP_WRITE, {cbm_pkg::DEC_PAT67, 10'h3FF, 2'd3}, 8'hFE, '0);
    arm_timer(16'd3, 1'b1);
    access(cbm_pkg::OP_TICK, '0, '0, 10'd2);
    access(cbm_pkg::OP_TICK, '0, '0, 10'd1);
    access(cbm_pkg::OP_TICK, '0, '0, 10'd1023);
    access(cbm_pkg::OP_WRITE, {cbm_pkg::DEC_CTRL, 10'h3FF, 2'd3}, 8'hFF, '0);
    access(cbm_pkg::OP_WRITE, {cbm_pkg::DEC_CTRL, 10'h000, cbm_pkg::CTRL_MIRROR}, 8'hFF, '0);
    access(cbm_pkg::OP_WRITE, {cbm_pkg::DEC_CTRL, 10'h000, cbm_pkg::CTRL_ACK}, 8'h01, '0);
    access(cbm_pkg::OP_TICK, '0, '0, 10'd0);
    access(cbm_pkg::OP_PRG, 16'h8000, '0, '0);
    access(cbm_pkg::OP_PRG, 16'hA000, '0, '0);
    access(cbm_pkg::OP_PAT, 16'hFC00, '0, '0);

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase > 0) begin
        // The register is only written once every result has come back.
        in_valid <= 1'b0;
        while (results_checked < items_sent) @(posedge clk);
        repeat (3) @(posedge clk);
        case (phase)
          1: setting = 9'd2;
          2: setting = 9'd256;
          4: setting = 9'd255;
          5: setting = 9'd3;
          default: setting = 9'($urandom_range(2, 256));
        endcase
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= setting;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
      end
      idle_on   = (phase < PHASES - 1);
      idle_odds = (phase % 2 == 0) ? 3 : 9;
      target    = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
          arm_timer(($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2000)),
                    $urandom_range(0, 5) != 0);
        end else if (pick < 34) begin
          access(cbm_pkg::OP_WRITE,
                 {4'($urandom_range(cbm_pkg::DEC_PRG01, cbm_pkg::DEC_CTRL)), 12'($urandom)},
                 8'($urandom), '0);
        end else if (pick < 42) begin
          access(cbm_pkg::OP_WRITE, 16'($urandom), 8'($urandom), '0);
        end else if (pick < 62) begin
          access(cbm_pkg::OP_TICK, '0, '0,
                 ($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'($urandom_range(0, 300)));
        end else if (pick < 82) begin
          access(cbm_pkg::OP_PRG, 16'($urandom), '0, '0);
        end else begin
          access(cbm_pkg::OP_PAT, 16'($urandom), '0, '0);
        end
      end
    end

    in_valid <= 1'b0;
    while (results_checked < items_sent) @(posedge clk);
    repeat (4) @(posedge clk);
    $display("Ran %0d bus accesses, ticks and lookups over %0d bank-count settings.",
             items_sent, PHASES);
    $display("Checked %0d results, %0d of them with the interrupt pending.",
             results_checked, irq_results);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("status: fail");
    end
    $finish;
  end

endmodule

[cartridge_bank_mapper_irq.f]
+incdir+rtl/core
rtl/core/cbm_pkg.sv
rtl/core/cbm_core.sv
rtl/core/cartridge_bank_mapper_irq.sv
dv/cartridge_bank_mapper_irq_check.sv
dv/cartridge_bank_mapper_irq_test.sv
